>>> rtl/core/plcmp_pkg.sv
// ----------------------------------------------------------------------------
// plcmp_pkg
// Shared types and constants for the pointer layout bitmap compatibility check.
// ----------------------------------------------------------------------------
`default_nettype none

package plcmp_pkg;

   localparam int MAP_W  = 64;
   localparam int CNT_W  = 6;
   localparam int STEP_W = 12;   // holds 63*62 sweep steps

   localparam logic [CNT_W-1:0] TOP_INDEX = 6'd63;

   typedef struct packed {
      logic [MAP_W-1:0] layout_a;
      logic [MAP_W-1:0] layout_b;
   } req_payload_type;

   typedef struct packed {
      logic [CNT_W-1:0] words_a;
      logic [CNT_W-1:0] words_b;
      logic             violated;
      logic             proved;
   } rsp_payload_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
   } count_stat_type;

   typedef struct packed {
      logic done;
      logic violated;
      logic proved;
   } sweep_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/plcmp_count.sv
// ----------------------------------------------------------------------------
// plcmp_count
// Bit-serial search for the highest set bit of a layout bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module plcmp_count (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [plcmp_pkg::MAP_W-1:0]   map,
   output plcmp_pkg::count_stat_type     stat
);

   logic [plcmp_pkg::MAP_W-1:0] shift_ff, shift_in;
   logic [plcmp_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [plcmp_pkg::CNT_W-1:0] count_ff, count_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   always_comb begin
      shift_in = shift_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = map;
         idx_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // last set bit seen from the bottom up is the terminator
         if (shift_ff[0]) begin
            count_in = idx_ff;
         end
         shift_in = shift_ff >> 1;
         idx_in   = idx_ff + 1'b1;
         if (idx_ff == plcmp_pkg::TOP_INDEX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done  = done_ff;
   assign stat.count = count_ff;

endmodule

`default_nettype wire

>>> rtl/core/plcmp_sweep.sv
// ----------------------------------------------------------------------------
// plcmp_sweep
// Rotating bit-serial comparison of two repeating layouts.
// ----------------------------------------------------------------------------
`default_nettype none

module plcmp_sweep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [plcmp_pkg::MAP_W-1:0]   map_a,
   input  logic [plcmp_pkg::MAP_W-1:0]   map_b,
   input  logic [plcmp_pkg::CNT_W-1:0]   count_a,
   input  logic [plcmp_pkg::CNT_W-1:0]   count_b,
   output plcmp_pkg::sweep_stat_type     stat
);

   logic [plcmp_pkg::MAP_W-1:0]  work_a_ff, work_a_in;
   logic [plcmp_pkg::MAP_W-1:0]  work_b_ff, work_b_in;
   logic [plcmp_pkg::CNT_W-1:0]  pos_a_ff, pos_a_in;
   logic [plcmp_pkg::CNT_W-1:0]  pos_b_ff, pos_b_in;
   logic [plcmp_pkg::CNT_W-1:0]  longer_ff, longer_in;
   logic [plcmp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         viol_ff, viol_in;
   logic                         prov_ff, prov_in;
   logic [plcmp_pkg::CNT_W-1:0]  inc_a, inc_b;
   logic                         wrap_a, wrap_b;

   assign inc_a  = pos_a_ff + 1'b1;
   assign inc_b  = pos_b_ff + 1'b1;
   assign wrap_a = (inc_a == count_a);
   assign wrap_b = (inc_b == count_b);

   always_comb begin
      work_a_in = work_a_ff;
      work_b_in = work_b_ff;
      pos_a_in  = pos_a_ff;
      pos_b_in  = pos_b_ff;
      longer_in = longer_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      viol_in   = viol_ff;
      prov_in   = prov_ff;
      if (start) begin
         if (count_a == '0 || count_b == '0) begin
            // an empty layout settles both flags at once
            done_in = 1'b1;
            viol_in = (count_a != '0) || (count_b != '0);
            prov_in = (count_a == '0) && (count_b == '0);
         end else begin
            work_a_in = map_a;
            work_b_in = map_b;
            pos_a_in  = '0;
            pos_b_in  = '0;
            step_in   = '0;
            longer_in = (count_a > count_b) ? count_a : count_b;
            busy_in   = 1'b1;
         end
      end else if (busy_ff) begin
         if (work_a_ff[0] != work_b_ff[0]) begin
            // a mismatch inside the longer layout's single pass is a violation
            busy_in = 1'b0;
            done_in = 1'b1;
            viol_in = (step_ff < {{(plcmp_pkg::STEP_W-plcmp_pkg::CNT_W){1'b0}}, longer_ff});
            prov_in = 1'b0;
         end else begin
            work_a_in = wrap_a ? map_a : (work_a_ff >> 1);
            work_b_in = wrap_b ? map_b : (work_b_ff >> 1);
            pos_a_in  = wrap_a ? '0 : inc_a;
            pos_b_in  = wrap_b ? '0 : inc_b;
            step_in   = step_ff + 1'b1;
            // both wrap together only at the least common multiple
            if (wrap_a && wrap_b) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               viol_in = 1'b0;
               prov_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      work_a_ff <= work_a_in;
      work_b_ff <= work_b_in;
      pos_a_ff  <= pos_a_in;
      pos_b_ff  <= pos_b_in;
      longer_ff <= longer_in;
      step_ff   <= step_in;
      viol_ff   <= viol_in;
      prov_ff   <= prov_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.violated = viol_ff;
   assign stat.proved   = prov_ff;

endmodule

`default_nettype wire

>>> rtl/core/pointer_layout_bitmap_compat.sv
// ----------------------------------------------------------------------------
// pointer_layout_bitmap_compat
// Compatibility check of two pointer layout bitmaps, one bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries two 64-bit layout bitmaps (req_data.layout_a/layout_b).
//   It is taken when req_valid is high and req_stall is low. One response per
//   request comes back on rsp_data: both word counts, the violation flag and
//   the proof flag, held until rsp_valid meets a low rsp_stall.
//   Steps: the request is loaded, the serial terminator search runs over
//   both maps (two scanners run side by side), then the rotating comparison
//   goes at one word position per cycle over at most lcm(words_a, words_b)
//   positions, stopping at the first mismatch; an empty layout skips it.
//   Last, the send state moves the result into the response register.
//   Throughput: one request at a time; req_stall stays high from acceptance
//   until the result is in the response register. The next request may be
//   taken while the previous response still waits on a stalled receiver.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   any pending response. A stalled response holds its data unchanged; a
//   finished check waits in the send state until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_layout_bitmap_compat (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  plcmp_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output plcmp_pkg::rsp_payload_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   plcmp_pkg::req_payload_type layout_ff, layout_in;
   plcmp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   plcmp_pkg::count_stat_type  cnt_a_stat, cnt_b_stat;
   plcmp_pkg::sweep_stat_type  sweep_stat;

   logic req_take;
   logic rsp_free;

   assign req_take = req_valid && !req_stall;
   // response register can take a new result this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // serial terminator search, one per layout
   plcmp_count u_count_a (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .map   (req_data.layout_a),
      .stat  (cnt_a_stat)
   );

   plcmp_count u_count_b (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .map   (req_data.layout_b),
      .stat  (cnt_b_stat)
   );

   // rotating comparison, started when both counts are known
   plcmp_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_COUNT && cnt_a_stat.done),
      .map_a   (layout_ff.layout_a),
      .map_b   (layout_ff.layout_b),
      .count_a (cnt_a_stat.count),
      .count_b (cnt_b_stat.count),
      .stat    (sweep_stat)
   );

   always_comb begin
      state_in     = state_ff;
      layout_in    = layout_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the response once the receiver takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               layout_in = req_data;
               state_in  = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cnt_a_stat.done) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_stat.done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // hold the finished result until the response register is free
            if (rsp_free) begin
               rsp_data_in.words_a  = cnt_a_stat.count;
               rsp_data_in.words_b  = cnt_b_stat.count;
               rsp_data_in.violated = sweep_stat.violated;
               rsp_data_in.proved   = sweep_stat.proved;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      layout_ff   <= layout_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/plcmp_checker.sv
// ----------------------------------------------------------------------------
// plcmp_checker
// Port-level checks for the pointer layout bitmap compatibility block.
// ----------------------------------------------------------------------------
`default_nettype none

module plcmp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input plcmp_pkg::rsp_payload_type rsp_data
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // agreement over the full repeat implies no violation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.proved |-> !rsp_data.violated)
      else $error("proved response flagged as violated");

   // both empty: proved, not violated
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.words_a == 6'd0 && rsp_data.words_b == 6'd0
         |-> rsp_data.proved && !rsp_data.violated)
      else $error("empty layouts not proved");

   // exactly one empty: violated, not proved
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.words_a == 6'd0) != (rsp_data.words_b == 6'd0))
         |-> rsp_data.violated && !rsp_data.proved)
      else $error("single empty layout mishandled");

endmodule

bind pointer_layout_bitmap_compat plcmp_checker u_plcmp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/compat_verdict_checker.sv
// ----------------------------------------------------------------------------
// compat_verdict_checker
// Watches both channels of the layout compatibility block, works out the
// verdict for every accepted request and compares each response against it.
// ----------------------------------------------------------------------------
module compat_verdict_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  plcmp_pkg::req_payload_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  plcmp_pkg::rsp_payload_type rsp_data,
   output int                         verdicts_owed,
   output int                         mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   plcmp_pkg::rsp_payload_type verdicts_due[$];
   int                         fail_tally = 0;

   // Index of the terminator, zero for an empty map.
   function automatic int unsigned terminator_index(
         input logic [plcmp_pkg::MAP_W-1:0] map);
      for (int i = plcmp_pkg::MAP_W - 1; i >= 0; i--) begin
         if (map[i]) return i;
      end
      return 0;
   endfunction

   // Single sweep of the longer layout against the repeating shorter one.
   function automatic logic sweep_disagrees(input logic [plcmp_pkg::MAP_W-1:0] longer,
                                            input logic [plcmp_pkg::MAP_W-1:0] shorter,
                                            input int unsigned n_long,
                                            input int unsigned n_short);
      int unsigned ps;
      if (n_short == 0) return (n_long > 0);
      ps = 0;
      for (int unsigned pl = 0; pl < n_long; pl++) begin
         if (longer[pl] != shorter[ps]) return 1'b1;
         ps = (ps + 1 == n_short) ? 0 : ps + 1;
      end
      return 1'b0;
   endfunction

   // Both layouts repeated over the lcm of their counts must match everywhere.
   function automatic logic repeats_agree(input logic [plcmp_pkg::MAP_W-1:0] ma,
                                          input logic [plcmp_pkg::MAP_W-1:0] mb,
                                          input int unsigned na,
                                          input int unsigned nb);
      int unsigned x, y, t, span, pa, pb;
      if (na == 0 && nb == 0) return 1'b1;
      if (na == 0 || nb == 0) return 1'b0;
      x = na;
      y = nb;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      span = (na * nb) / x;
      pa = 0;
      pb = 0;
      for (int unsigned k = 0; k < span; k++) begin
         if (ma[pa] != mb[pb]) return 1'b0;
         pa = (pa + 1 == na) ? 0 : pa + 1;
         pb = (pb + 1 == nb) ? 0 : pb + 1;
      end
      return 1'b1;
   endfunction

   function automatic plcmp_pkg::rsp_payload_type compat_verdict(
         input plcmp_pkg::req_payload_type req);
      plcmp_pkg::rsp_payload_type v;
      int unsigned                na, nb;
      na = terminator_index(req.layout_a);
      nb = terminator_index(req.layout_b);
      v.words_a = na[plcmp_pkg::CNT_W-1:0];
      v.words_b = nb[plcmp_pkg::CNT_W-1:0];
      // equal counts sweep layout_b as the longer one
      if (na > nb) v.violated = sweep_disagrees(req.layout_a, req.layout_b, na, nb);
      else         v.violated = sweep_disagrees(req.layout_b, req.layout_a, nb, na);
      v.proved = repeats_agree(req.layout_a, req.layout_b, na, nb);
      return v;
   endfunction

   always @(posedge clock) begin
      plcmp_pkg::rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) verdicts_due.push_back(compat_verdict(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("unexpected response: words %0d/%0d violated %0b proved %0b",
                           rsp_data.words_a, rsp_data.words_b, rsp_data.violated,
                           rsp_data.proved);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.words_a !== want.words_a || rsp_data.words_b !== want.words_b ||
                   rsp_data.violated !== want.violated || rsp_data.proved !== want.proved) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display({"mismatch: expected words %0d/%0d violated %0b proved %0b,",
                               " got words %0d/%0d violated %0b proved %0b"},
                              want.words_a, want.words_b, want.violated, want.proved,
                              rsp_data.words_a, rsp_data.words_b, rsp_data.violated,
                              rsp_data.proved);
               end
            end
         end
      end
      verdicts_owed <= verdicts_due.size();
      mismatches    <= fail_tally;
   end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pointer layout bitmap compatibility block:
// directed corner pairs, then random layout pairs under three idling mixes,
// with the checker beside the block predicting and comparing every response.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // hard stop for the whole run; the run stays far below this limit
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 4100;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   plcmp_pkg::req_payload_type req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   plcmp_pkg::rsp_payload_type rsp_data;

   int verdicts_owed;
   int mismatches;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   pointer_layout_bitmap_compat u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   compat_verdict_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .verdicts_owed (verdicts_owed),
      .mismatches    (mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the response channel at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request and return at the edge that takes it. Valid is only
   // dropped when a gap is inserted, so a back-to-back request keeps it high.
   task automatic send_pair(input logic [plcmp_pkg::MAP_W-1:0] map_a,
                            input logic [plcmp_pkg::MAP_W-1:0] map_b);
      plcmp_pkg::req_payload_type item;
      item.layout_a = map_a;
      item.layout_b = map_b;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // hold the payload until an edge sees stall low
      do @(posedge clock); while (req_stall);
   endtask

   // Repeat a base pattern of the given period below the count, then place
   // the terminator at the count. Count zero leaves only bit 0 set (empty).
   function automatic logic [plcmp_pkg::MAP_W-1:0] build_layout(input int unsigned count,
                                                                input logic [7:0] base,
                                                                input int unsigned period);
      logic [plcmp_pkg::MAP_W-1:0] map;
      map = '0;
      for (int unsigned i = 0; i < count; i++) map[i] = base[i % period];
      map[count] = 1'b1;
      return map;
   endfunction

   // Mostly well-formed pairs built from one shared period so that the proof
   // sweep runs to the end; then broken pairs with one flipped mark or one
   // emptied side; the rest is raw noise across all 64 bits.
   task automatic send_random_pair();
      int unsigned                 kind, period, cap, na, nb, pos;
      logic [7:0]                  base;
      logic [plcmp_pkg::MAP_W-1:0] map_a, map_b;
      kind   = $urandom_range(99);
      period = $urandom_range(1, 8);
      base   = 8'($urandom);
      // keep most counts short, a few reach the full width
      cap    = ($urandom_range(9) == 0) ? 63 : 16;
      na     = period * $urandom_range(1, cap / period);
      nb     = period * $urandom_range(1, cap / period);
      map_a  = build_layout(na, base, period);
      map_b  = build_layout(nb, base, period);
      if (kind < 60) begin
         send_pair(map_a, map_b);
      end else if (kind < 80) begin
         if ($urandom_range(3) == 0) begin
            // empty one side, as zero or as a lone bit 0
            if ($urandom_range(1))
               map_a = {{(plcmp_pkg::MAP_W-1){1'b0}}, 1'($urandom_range(1))};
            else
               map_b = {{(plcmp_pkg::MAP_W-1){1'b0}}, 1'($urandom_range(1))};
         end else if ($urandom_range(1)) begin
            pos = $urandom_range(0, na - 1);
            map_a[pos] = ~map_a[pos];
         end else begin
            pos = $urandom_range(0, nb - 1);
            map_b[pos] = ~map_b[pos];
         end
         send_pair(map_a, map_b);
      end else begin
         map_a = {$urandom, $urandom};
         map_b = {$urandom, $urandom};
         if ($urandom_range(1)) map_a = map_a >> $urandom_range(0, 63);
         if ($urandom_range(1)) map_b = map_b >> $urandom_range(0, 63);
         send_pair(map_a, map_b);
      end
   endtask

   initial begin
      // hold reset at the start, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles rarely, receiver stalls often
      send_idle_pct = 12;
      recv_idle_pct = 67;

      // both empty, as zero and as a lone bit 0
      send_pair(64'h0, 64'h0);
      send_pair(64'h1, 64'h1);
      send_pair(64'h0, 64'h1);
      // every mark set at full width
      send_pair({plcmp_pkg::MAP_W{1'b1}}, {plcmp_pkg::MAP_W{1'b1}});
      // exactly one side empty, shorter empty against a longer layout
      send_pair({plcmp_pkg::MAP_W{1'b1}}, 64'h0);
      send_pair(64'h1, {plcmp_pkg::MAP_W{1'b1}});
      // terminator only at the top, no pointer words
      send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      // counts 63 and 62 that agree: longest proof sweep
      send_pair(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
      send_pair({plcmp_pkg::MAP_W{1'b1}}, 64'h7FFF_FFFF_FFFF_FFFF);
      // equal counts with one differing mark
      send_pair(64'b1101, 64'b1100);
      // terminators sit at different positions but are never compared
      send_pair(64'b10, 64'b100);
      send_pair(64'b11, 64'b111);
      // shorter pattern repeats cleanly inside the longer, both orders
      send_pair(64'b101, 64'b1_0101);
      send_pair(64'b1_0101, 64'b101);
      // sweep passes but the repeats drift apart over the lcm
      send_pair(64'b101, 64'b1101);
      send_pair(64'b1101, 64'b101);
      // alternating patterns out of phase, then in phase
      send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_pair(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
      // top bit set on one side only
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003);

      repeat (40) send_random_pair();

      // phase two: sender idles often, receiver stalls rarely
      send_idle_pct = 67;
      recv_idle_pct = 12;
      repeat (40) send_random_pair();

      // phase three: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (41) send_random_pair();

      // drop valid, let the last request reach the checker, then drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && verdicts_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
